[design/sksst_pkg.sv]
// ----------------------------------------------------------------------------
// sksst_pkg
// Shared types and codes of the string key sort and search table.
// ----------------------------------------------------------------------------
package sksst_pkg;

  localparam int unsigned TagW    = 6;
  localparam int unsigned StatusW = 3;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_SORT  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_ORDER    = 3'd0,
    ST_MATCH    = 3'd1,
    ST_NO_MATCH = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_e;

  typedef struct packed {
    logic [TagW-1:0]    tag;
    logic [StatusW-1:0] status;
    logic               last;
  } res_t;

endpackage

[design/string_key_sort_search_table.sv]
// ----------------------------------------------------------------------------
// string_key_sort_search_table
// Byte-string key table with exchange sort, equality search and tag report.
// ----------------------------------------------------------------------------
// Key and query bytes: one request per cycle while idle; a sort, a query's last
//   byte or a refused request holds input off until its results reach the result register.
// Sort: exchange sort over all i<j key pairs, then a tag per row; paced by the single key memory port.
// Search: compares the query with every stored entry.
// Reset clears counts and control only; the stores hold nothing until written.
// ----------------------------------------------------------------------------
module string_key_sort_search_table #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_BYTES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       req_type_i,
  input  logic [7:0]                       key_byte_i,
  input  logic                             key_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sksst_pkg::TagW-1:0]       entry_tag_o,
  output logic [sksst_pkg::StatusW-1:0]    status_o,
  output logic                             last_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(KEY_BYTES + 1);
  localparam int unsigned KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned AW = (CAPACITY * KEY_BYTES > 1) ? $clog2(CAPACITY * KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_LOAD, S_LEN, S_RA, S_RB, S_CMP, S_NEXT, S_EFETCH, S_EMIT,
    S_PUSHM, S_SFIN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q, i_q, j_q;
  logic [LW-1:0]   bpos_q, qlen_q, qlen_s_q, k_q, la_q, lb_q;
  logic [IW-1:0]   ra_q, rb_q, held_q, newtag_q;
  logic            search_q, have_q, done_q, gt_q, eq_q;
  logic [7:0]      abyte_q;
  sksst_pkg::res_t pend_q;

  // stores: key bytes by row, query bytes, row order and row lengths
  logic [7:0]    kmem  [CAPACITY*KEY_BYTES];
  logic [7:0]    qmem  [KEY_BYTES];
  logic [IW-1:0] perm  [CAPACITY];
  logic [LW-1:0] klen  [CAPACITY];
  logic [7:0]    krd_q, qrd_q;

  logic            accept, free, push;
  sksst_pkg::res_t push_res, out_res;
  logic            kwe, qwe;
  logic [AW-1:0]   kwaddr, kraddr;
  logic [LW-1:0]   n_len;
  logic [7:0]      cmp_a, cmp_b;
  logic [IW-1:0]   slot;
  logic            is_add, is_query, can_add, can_query;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign slot      = cnt_q[IW-1:0];
  assign is_add    = accept && (req_type_i == sksst_pkg::REQ_ADD);
  assign is_query  = accept && (req_type_i == sksst_pkg::REQ_QUERY);
  assign can_add   = (cnt_q != CW'(CAPACITY)) && (bpos_q < LW'(KEY_BYTES));
  assign can_query = (qlen_q < LW'(KEY_BYTES));
  assign kwe       = is_add && can_add;
  assign qwe       = is_query && can_query;
  assign kwaddr    = AW'(slot) * AW'(KEY_BYTES) + AW'(bpos_q);
  assign kraddr    = ((state_q == S_RB) ? AW'(rb_q) : AW'(ra_q)) * AW'(KEY_BYTES) + AW'(k_q);
  assign n_len     = (la_q < lb_q) ? la_q : lb_q;
  assign cmp_a     = search_q ? krd_q : abyte_q;
  assign cmp_b     = search_q ? qrd_q : krd_q;

  always_ff @(posedge clk_i) begin
    if (kwe) begin
      kmem[kwaddr] <= key_byte_i;
    end
    krd_q <= kmem[kraddr];
  end

  always_ff @(posedge clk_i) begin
    if (qwe) begin
      qmem[qlen_q[KW-1:0]] <= key_byte_i;
    end
    qrd_q <= qmem[k_q[KW-1:0]];
  end

  // commit a new row at the end of the order; exchange two positions on sort
  always_ff @(posedge clk_i) begin
    if (is_add && (cnt_q != CW'(CAPACITY)) && key_end_i) begin
      perm[slot] <= slot;
      klen[slot] <= can_add ? bpos_q + LW'(1) : bpos_q;
    end else if (state_q == S_NEXT && !search_q && gt_q) begin
      perm[i_q[IW-1:0]] <= rb_q;
      perm[j_q[IW-1:0]] <= ra_q;
    end
  end

  // push selection towards the result register
  always_comb begin
    push     = 1'b0;
    push_res = pend_q;
    case (state_q)
      S_RES: begin
        push = 1'b1;
      end
      S_EMIT: begin
        push         = 1'b1;
        push_res.tag = sksst_pkg::TagW'(ra_q);
        push_res.status = sksst_pkg::ST_ORDER;
        push_res.last = (i_q + CW'(1) == cnt_q);
      end
      S_PUSHM: begin
        push         = 1'b1;
        push_res.tag = sksst_pkg::TagW'(held_q);
        push_res.status = sksst_pkg::ST_MATCH;
        push_res.last = 1'b0;
      end
      S_SFIN: begin
        push         = 1'b1;
        push_res.tag = have_q ? sksst_pkg::TagW'(held_q) : '0;
        push_res.status = have_q ? sksst_pkg::ST_MATCH : sksst_pkg::ST_NO_MATCH;
        push_res.last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      bpos_q   <= '0;
      qlen_q   <= '0;
      qlen_s_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      la_q     <= '0;
      lb_q     <= '0;
      ra_q     <= '0;
      rb_q     <= '0;
      held_q   <= '0;
      newtag_q <= '0;
      search_q <= 1'b0;
      have_q   <= 1'b0;
      done_q   <= 1'b0;
      gt_q     <= 1'b0;
      eq_q     <= 1'b0;
      abyte_q  <= '0;
      pend_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_i)
              sksst_pkg::REQ_ADD: begin
                if (cnt_q == CW'(CAPACITY)) begin
                  pend_q  <= '{tag: '0, status: sksst_pkg::ST_FULL, last: 1'b1};
                  state_q <= S_RES;
                end else begin
                  if (key_end_i) begin
                    cnt_q  <= cnt_q + CW'(1);
                    bpos_q <= '0;
                  end else if (can_add) begin
                    bpos_q <= bpos_q + LW'(1);
                  end
                  if (!can_add) begin
                    pend_q  <= '{tag: sksst_pkg::TagW'(slot),
                                 status: sksst_pkg::ST_TOO_LONG, last: 1'b1};
                    state_q <= S_RES;
                  end
                end
              end
              sksst_pkg::REQ_SORT: begin
                search_q <= 1'b0;
                i_q      <= '0;
                j_q      <= CW'(1);
                if (cnt_q == '0) begin
                  pend_q  <= '{tag: '0, status: sksst_pkg::ST_EMPTY, last: 1'b1};
                  state_q <= S_RES;
                end else if (cnt_q == CW'(1)) begin
                  state_q <= S_EFETCH;
                end else begin
                  state_q <= S_LOAD;
                end
              end
              sksst_pkg::REQ_QUERY: begin
                if (!can_query) begin
                  if (key_end_i) begin
                    qlen_q <= '0;
                  end
                  pend_q  <= '{tag: '0, status: sksst_pkg::ST_TOO_LONG, last: 1'b1};
                  state_q <= S_RES;
                end else if (!key_end_i) begin
                  qlen_q <= qlen_q + LW'(1);
                end else begin
                  qlen_q   <= '0;
                  qlen_s_q <= qlen_q + LW'(1);
                  search_q <= 1'b1;
                  have_q   <= 1'b0;
                  i_q      <= '0;
                  if (cnt_q == '0) begin
                    pend_q  <= '{tag: '0, status: sksst_pkg::ST_EMPTY, last: 1'b1};
                    state_q <= S_RES;
                  end else begin
                    state_q <= S_LOAD;
                  end
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RES: begin
          if (free) begin
            state_q <= S_IDLE;
          end
        end
        // fetch the two rows from the order, then their lengths
        S_LOAD: begin
          ra_q    <= perm[i_q[IW-1:0]];
          rb_q    <= perm[j_q[IW-1:0]];
          k_q     <= '0;
          state_q <= S_LEN;
        end
        S_LEN: begin
          la_q    <= klen[ra_q];
          lb_q    <= search_q ? qlen_s_q : klen[rb_q];
          state_q <= S_RA;
        end
        S_RA: begin
          if (k_q == n_len) begin
            gt_q    <= (la_q > lb_q);
            eq_q    <= (la_q == lb_q);
            state_q <= S_NEXT;
          end else begin
            state_q <= search_q ? S_CMP : S_RB;
          end
        end
        S_RB: begin
          abyte_q <= krd_q;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp_a != cmp_b) begin
            gt_q    <= (cmp_a > cmp_b);
            eq_q    <= 1'b0;
            state_q <= S_NEXT;
          end else begin
            k_q     <= k_q + LW'(1);
            state_q <= S_RA;
          end
        end
        S_NEXT: begin
          if (search_q) begin
            done_q <= (i_q + CW'(1) == cnt_q);
            i_q    <= i_q + CW'(1);
            if (eq_q && have_q) begin
              newtag_q <= ra_q;
              state_q  <= S_PUSHM;
            end else begin
              if (eq_q) begin
                have_q <= 1'b1;
                held_q <= ra_q;
              end
              state_q <= (i_q + CW'(1) == cnt_q) ? S_SFIN : S_LOAD;
            end
          end else if (j_q + CW'(1) == cnt_q) begin
            j_q <= i_q + CW'(2);
            i_q <= i_q + CW'(1);
            if (i_q + CW'(2) == cnt_q) begin
              i_q     <= '0;
              state_q <= S_EFETCH;
            end else begin
              state_q <= S_LOAD;
            end
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_LOAD;
          end
        end
        // fetch the row at the current position, then report its tag
        S_EFETCH: begin
          ra_q    <= perm[i_q[IW-1:0]];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (free) begin
            i_q <= i_q + CW'(1);
            if (i_q + CW'(1) == cnt_q) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_EFETCH;
            end
          end
        end
        S_PUSHM: begin
          if (free) begin
            held_q  <= newtag_q;
            state_q <= done_q ? S_SFIN : S_LOAD;
          end
        end
        S_SFIN: begin
          if (free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  sksst_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (push_res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign entry_tag_o = out_res.tag;
  assign status_o    = out_res.status;
  assign last_o      = out_res.last;

endmodule

[design/sksst_outreg.sv]
// ----------------------------------------------------------------------------
// sksst_outreg
// One-entry result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module sksst_outreg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sksst_pkg::res_t  res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sksst_pkg::res_t  res_o
);

  logic            valid_q;
  sksst_pkg::res_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && free_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

[bench/tb_string_key_sort_search_table.sv]
// ----------------------------------------------------------------------------
// tb_string_key_sort_search_table
// Drives key, sort and query requests into the key table and checks every
// reported tag, status and last flag against a behavioural model kept in the bench.
// ----------------------------------------------------------------------------
module tb_string_key_sort_search_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 64;
  localparam int unsigned KB  = 32;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] kbyte;
    logic       kend;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = 2'd0;
  logic [7:0] key_byte_i = 8'd0;
  logic key_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [sksst_pkg::TagW-1:0] entry_tag_o;
  logic [sksst_pkg::StatusW-1:0] status_o;
  logic last_o;

  string_key_sort_search_table #(.CAPACITY(CAP), .KEY_BYTES(KB)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state of the table
  logic [7:0] mdl_keys [CAP][KB];
  int unsigned mdl_len [CAP];
  logic [5:0] mdl_tag [CAP];
  int unsigned mdl_count, mdl_pos, mdl_qlen;
  logic [7:0] mdl_query [KB];

  request_t pending_q[$];
  sksst_pkg::res_t expected_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;       // no idling in the final part of the run
  bit stall_go = 1'b0;   // starts the long receiver stall
  bit hold_off = 1'b0;   // receiver held off while set

  function automatic int key_cmp(int unsigned a, int unsigned b, bit vs_query);
    int unsigned la, lb, n;
    logic [7:0] x, y;
    la = mdl_len[a];
    lb = vs_query ? mdl_qlen : mdl_len[b];
    n = la < lb ? la : lb;
    for (int unsigned k = 0; k < n; k++) begin
      x = mdl_keys[a][k];
      y = vs_query ? mdl_query[k] : mdl_keys[b][k];
      if (x != y) return x < y ? -1 : 1;
    end
    if (la == lb) return 0;
    return la < lb ? -1 : 1;
  endfunction

  function automatic void push_result(logic [5:0] tag, sksst_pkg::status_e st, bit lst);
    sksst_pkg::res_t r;
    r.tag = tag;
    r.status = st;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  // Advance the model by one accepted request and queue its results
  function automatic void predict_table(request_t rq);
    int unsigned slot, hits, seen;
    bit flagged;
    logic [7:0] row [KB];
    int unsigned tl;
    logic [5:0] tt;
    case (sksst_pkg::req_e'(rq.req))
      sksst_pkg::REQ_ADD: begin
        if (mdl_count >= CAP) begin
          push_result('0, sksst_pkg::ST_FULL, 1'b1);
          return;
        end
        slot = mdl_count;
        flagged = 1'b0;
        if (mdl_pos < KB) begin
          mdl_keys[slot][mdl_pos] = rq.kbyte;
          mdl_pos++;
        end else flagged = 1'b1;
        if (rq.kend) begin
          mdl_len[slot] = mdl_pos;
          mdl_tag[slot] = slot[5:0];
          mdl_count++;
          mdl_pos = 0;
        end
        if (flagged) push_result(slot[5:0], sksst_pkg::ST_TOO_LONG, 1'b1);
      end
      sksst_pkg::REQ_SORT: begin
        if (mdl_count == 0) begin
          push_result('0, sksst_pkg::ST_EMPTY, 1'b1);
          return;
        end
        for (int unsigned i = 0; i + 1 < mdl_count; i++)
          for (int unsigned j = i + 1; j < mdl_count; j++)
            if (key_cmp(i, j, 1'b0) > 0) begin
              row = mdl_keys[i]; mdl_keys[i] = mdl_keys[j]; mdl_keys[j] = row;
              tl = mdl_len[i]; mdl_len[i] = mdl_len[j]; mdl_len[j] = tl;
              tt = mdl_tag[i]; mdl_tag[i] = mdl_tag[j]; mdl_tag[j] = tt;
            end
        for (int unsigned i = 0; i < mdl_count; i++)
          push_result(mdl_tag[i], sksst_pkg::ST_ORDER, i + 1 == mdl_count);
      end
      sksst_pkg::REQ_QUERY: begin
        if (mdl_qlen >= KB) begin
          if (rq.kend) mdl_qlen = 0;
          push_result('0, sksst_pkg::ST_TOO_LONG, 1'b1);
          return;
        end
        mdl_query[mdl_qlen] = rq.kbyte;
        mdl_qlen++;
        if (!rq.kend) return;
        if (mdl_count == 0) begin
          mdl_qlen = 0;
          push_result('0, sksst_pkg::ST_EMPTY, 1'b1);
          return;
        end
        hits = 0;
        for (int unsigned i = 0; i < mdl_count; i++)
          if (key_cmp(i, 0, 1'b1) == 0) hits++;
        seen = 0;
        for (int unsigned i = 0; i < mdl_count; i++)
          if (key_cmp(i, 0, 1'b1) == 0) begin
            seen++;
            push_result(mdl_tag[i], sksst_pkg::ST_MATCH, seen == hits);
          end
        mdl_qlen = 0;
        if (hits == 0) push_result('0, sksst_pkg::ST_NO_MATCH, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s at %0t", what, $realtime);
    errors++;
  endtask

  // Driver: offer the head of the pending queue, with random idle bursts
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_table(pending_q.pop_front());
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 4);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        req_type_i <= pending_q[0].req;
        key_byte_i <= pending_q[0].kbyte;
        key_end_i <= pending_q[0].kend;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver stall, counted here in cycles
  initial begin
    wait (stall_go);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor: compare each accepted result with the oldest expectation
  int recv_gap = 0;
  always @(posedge clk_i) begin
    sksst_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result");
        else begin
          want = expected_q.pop_front();
          if (entry_tag_o !== want.tag)
            report_mismatch($sformatf("tag %0d want %0d", entry_tag_o, want.tag));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d want %0d", status_o, want.status));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b want %0b", last_o, want.last));
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0) recv_gap = $urandom_range(1, 4);
      end
    end
  end

  function automatic void add_request(sksst_pkg::req_e r, logic [7:0] b, bit e);
    request_t rq;
    rq.req = r;
    rq.kbyte = b;
    rq.kend = e;
    pending_q.push_back(rq);
  endfunction

  // Queue a whole key (add or query) of the given bytes
  function automatic void add_key(sksst_pkg::req_e r, int unsigned n, logic [7:0] seed,
                                  bit rnd);
    for (int unsigned k = 0; k < n; k++)
      add_request(r, rnd ? 8'($urandom_range(0, 3)) : seed, k + 1 == n);
  endfunction

  initial begin
    int unsigned n, pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, zero and full-range bytes, prefixes, overlong keys
    add_request(sksst_pkg::REQ_SORT, 8'hA5, 1'b1);
    add_request(sksst_pkg::REQ_QUERY, 8'h00, 1'b1);
    add_request(sksst_pkg::REQ_NONE, 8'hFF, 1'b1);
    add_key(sksst_pkg::REQ_ADD, 2, 8'hFF, 1'b0);
    add_key(sksst_pkg::REQ_ADD, 1, 8'hFF, 1'b0);
    add_key(sksst_pkg::REQ_ADD, 1, 8'h00, 1'b0);
    add_key(sksst_pkg::REQ_ADD, 1, 8'hFF, 1'b0);
    add_request(sksst_pkg::REQ_SORT, 8'h00, 1'b0);
    add_key(sksst_pkg::REQ_QUERY, 1, 8'hFF, 1'b0);
    add_key(sksst_pkg::REQ_QUERY, 1, 8'h55, 1'b0);
    add_key(sksst_pkg::REQ_ADD, KB + 2, 8'hAA, 1'b0);     // overlong key, commit on the drop
    add_key(sksst_pkg::REQ_QUERY, KB + 2, 8'hAA, 1'b0);   // overlong query, abandoned
    add_key(sksst_pkg::REQ_QUERY, KB, 8'hAA, 1'b0);
    while (!stim_done && pending_q.size() > 0) @(posedge clk_i);

    // Random: mostly short keys over a small alphabet so that ties and
    // matches are common, with interleaved queries and sorts
    for (int it = 0; it < 60; it++) begin
      pick = $urandom_range(0, 19);
      n = $urandom_range(0, 9) == 0 ? $urandom_range(1, KB + 2) : $urandom_range(1, 3);
      if (pick < 9) add_key(sksst_pkg::REQ_ADD, n, 8'h00, 1'b1);
      else if (pick < 15) add_key(sksst_pkg::REQ_QUERY, n, 8'h00, 1'b1);
      else if (pick < 17) add_request(sksst_pkg::REQ_SORT, 8'($urandom), 1'($urandom));
      else if (pick < 18) add_request(sksst_pkg::REQ_NONE, 8'($urandom), 1'($urandom));
      else add_request(sksst_pkg::req_e'($urandom_range(0, 2)), 8'($urandom),
                       1'($urandom));
      if (it == 30) begin
        // Long receiver stall while requests keep coming
        while (pending_q.size() > 60) @(posedge clk_i);
        stall_go = 1'b1;
      end
    end

    // Drain, then fill the table to capacity and probe the full case
    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    calm = 1'b1;
    for (int unsigned k = mdl_count; k < CAP; k++)
      add_key(sksst_pkg::REQ_ADD, 1, 8'($urandom), 1'b0);
    add_request(sksst_pkg::REQ_ADD, 8'hFF, 1'b1);
    add_request(sksst_pkg::REQ_SORT, 8'h00, 1'b0);
    add_key(sksst_pkg::REQ_QUERY, 1, 8'hFF, 1'b0);

    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
